// ===== src/svoa_pkg.sv =====
// ----------------------------------------------------------------------------
// svoa_pkg: shared types, constants and tables of the synth voice
// envelope rate table, sustain levels, exponential divider, register indexes
// ----------------------------------------------------------------------------
package svoa_pkg;

	localparam int PHASE_W = 24;
	localparam int NOISE_W = 23;
	localparam int RATE_W  = 15;
	localparam int LEVEL_W = 8;
	localparam int WAVE_W  = 16;
	localparam int FREQ_W  = 16;
	localparam int PW_W    = 12;
	localparam int CTRL_W  = 8;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam int S_DATA_W = 32;
	localparam int M_DATA_W = 80;

	localparam logic [NOISE_W-1:0] NOISE_SEED = 23'h7ffff8;
	localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 8'hff;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_FREQUENCY       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_WIDTH     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CONTROL         = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ATTACK_DECAY    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN_RELEASE = 3'd4;

	// waveform select codes (control bits 7..4)
	localparam logic [3:0] WAVE_TRI       = 4'h1;
	localparam logic [3:0] WAVE_SAW       = 4'h2;
	localparam logic [3:0] WAVE_PULSE     = 4'h4;
	localparam logic [3:0] WAVE_PULSE_TRI = 4'h5;
	localparam logic [3:0] WAVE_PULSE_SAW = 4'h6;
	localparam logic [3:0] WAVE_PULSE_TS  = 4'h7;
	localparam logic [3:0] WAVE_NOISE     = 4'h8;

	typedef enum logic [1:0] {
		PH_ATTACK  = 2'd0,
		PH_DECAY   = 2'd1,
		PH_RELEASE = 2'd2
	} env_phase_t;

	// envelope step period in ticks
	function automatic logic [RATE_W-1:0] rate_lookup(input logic [3:0] idx);
		logic [RATE_W-1:0] r;
		case (idx)
			4'd0:    r = 15'd9;
			4'd1:    r = 15'd32;
			4'd2:    r = 15'd63;
			4'd3:    r = 15'd95;
			4'd4:    r = 15'd149;
			4'd5:    r = 15'd220;
			4'd6:    r = 15'd267;
			4'd7:    r = 15'd313;
			4'd8:    r = 15'd392;
			4'd9:    r = 15'd977;
			4'd10:   r = 15'd1954;
			4'd11:   r = 15'd3126;
			4'd12:   r = 15'd3907;
			4'd13:   r = 15'd11720;
			4'd14:   r = 15'd19532;
			default: r = 15'd31251;
		endcase
		return r;
	endfunction

	function automatic logic [LEVEL_W-1:0] sustain_level(input logic [3:0] idx);
		return {idx, idx};
	endfunction

	// piecewise-exponential decay divider
	function automatic logic [4:0] exp_div(input logic [LEVEL_W-1:0] lvl);
		logic [4:0] d;
		case (lvl) inside
			[8'd1:8'd5]:   d = 5'd30;
			[8'd6:8'd13]:  d = 5'd16;
			[8'd14:8'd25]: d = 5'd8;
			[8'd26:8'd51]: d = 5'd4;
			[8'd52:8'd92]: d = 5'd2;
			default:       d = 5'd1;
		endcase
		return d;
	endfunction

endpackage

// ===== src/synth_voice_osc_adsr.sv =====
// ----------------------------------------------------------------------------
// synth_voice_osc_adsr: one oscillator voice with adsr envelope
// a beat goes from the input register to the result register when that is free
// throughput: one beat per cycle unless m_tready stalls the result register
// the whole tick (envelope, accumulator, noise, wave, product) is one pass
// reset: async active low; config regs 0, accumulator 0, noise seed 0x7ffff8,
// envelope in release at level 0, both pipeline stages empty
// ----------------------------------------------------------------------------
module synth_voice_osc_adsr
	import svoa_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write port
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// input stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// advance[0], source_phase[24:1], source_sync_pulse[25], zero pad
	input  logic [S_DATA_W-1:0]   s_tdata,
	// result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// wave_value[15:0], envelope_level[23:16], scaled_sample[47:24],
	// sync_pulse[48], phase[72:49], zero pad
	output logic [M_DATA_W-1:0]   m_tdata
);

	// configuration registers
	logic [FREQ_W-1:0]  freq_q;
	logic [PW_W-1:0]    pw_q;
	logic [CTRL_W-1:0]  ctrl_q;
	logic [7:0]         ad_q;
	logic [7:0]         sr_q;

	// voice state
	logic [PHASE_W-1:0] phase_acc_q;
	logic [NOISE_W-1:0] noise_q;
	logic [RATE_W-1:0]  rate_cnt_q;
	logic [7:0]         exp_cnt_q;
	logic [LEVEL_W-1:0] env_level_q;
	env_phase_t         env_phase_q;

	// input stage
	logic               valid_s1;
	logic               adv_s1;
	logic [PHASE_W-1:0] src_phase_s1;
	logic               src_sync_s1;

	// result stage
	logic               out_valid_q;
	logic [M_DATA_W-1:0] out_data_q;

	logic stage_go;

	// the input stage moves whenever the result register is free or draining
	assign stage_go = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || stage_go;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// control bit fields
	logic       gate;
	logic       sync_en;
	logic       ring_en;
	logic       test_en;
	logic [3:0] wave_sel;

	assign gate     = ctrl_q[0];
	assign sync_en  = ctrl_q[1];
	assign ring_en  = ctrl_q[2];
	assign test_en  = ctrl_q[3];
	assign wave_sel = ctrl_q[7:4];

	// ---------------------------------------------------------------- envelope
	env_phase_t         ph_n;
	logic [RATE_W-1:0]  rate_sel;
	logic [RATE_W-1:0]  rc_inc;
	logic [RATE_W-1:0]  rate_cnt_n;
	logic [7:0]         ec_inc;
	logic [7:0]         exp_cnt_n;
	logic [LEVEL_W-1:0] level_n;

	always_comb begin
		// gate picks the phase before the step
		ph_n = env_phase_q;
		if (gate) begin
			if (env_phase_q != PH_ATTACK && env_phase_q != PH_DECAY) begin
				ph_n = PH_ATTACK;
			end
		end else begin
			ph_n = PH_RELEASE;
		end

		case (ph_n)
			PH_ATTACK: rate_sel = rate_lookup(ad_q[7:4]);
			PH_DECAY:  rate_sel = rate_lookup(ad_q[3:0]);
			default:   rate_sel = rate_lookup(sr_q[3:0]);
		endcase

		rc_inc     = rate_cnt_q + 15'd1;
		ec_inc     = exp_cnt_q + 8'd1;
		rate_cnt_n = rc_inc;
		exp_cnt_n  = exp_cnt_q;
		level_n    = env_level_q;

		// rate counter hit: one envelope step
		if (rc_inc == rate_sel) begin
			rate_cnt_n = '0;
			case (ph_n)
				PH_ATTACK: begin
					exp_cnt_n = '0;
					if (env_level_q != LEVEL_MAX) begin
						level_n = env_level_q + 8'd1;
					end
					// attack tops out at full scale and hands over to decay
					if (level_n == LEVEL_MAX) begin
						ph_n = PH_DECAY;
					end
				end
				PH_DECAY: begin
					exp_cnt_n = ec_inc;
					if (ec_inc >= {3'b0, exp_div(env_level_q)}) begin
						exp_cnt_n = '0;
						if (env_level_q > sustain_level(sr_q[7:4])) begin
							level_n = env_level_q - 8'd1;
						end
					end
				end
				default: begin
					// release stops quietly at zero
					if (env_level_q != '0) begin
						exp_cnt_n = ec_inc;
						if (ec_inc >= {3'b0, exp_div(env_level_q)}) begin
							exp_cnt_n = '0;
							level_n   = env_level_q - 8'd1;
						end
					end
				end
			endcase
		end
	end

	// ------------------------------------------------------------- oscillator
	logic [PHASE_W-1:0] ph_sum;
	logic [PHASE_W-1:0] phase_n;
	logic [NOISE_W-1:0] noise_n;
	logic               sync_n;

	assign ph_sum = phase_acc_q + {{(PHASE_W-FREQ_W){1'b0}}, freq_q};

	always_comb begin
		phase_n = phase_acc_q;
		noise_n = noise_q;
		sync_n  = 1'b0;
		if (test_en) begin
			// test bit holds the accumulator at zero and freezes the noise
			phase_n = '0;
		end else if (freq_q != '0) begin
			phase_n = ph_sum;
			if (!phase_acc_q[19] && ph_sum[19]) begin
				noise_n = {noise_q[NOISE_W-2:0], noise_q[22] ^ noise_q[17]};
			end
			sync_n = !phase_acc_q[23] && ph_sum[23];
		end
		// hard sync from the neighbor clears after our own pulse check
		if (sync_en && src_sync_s1) begin
			phase_n = '0;
		end
	end

	// state seen by the wave logic: stepped on advance, current otherwise
	logic [PHASE_W-1:0] phase_e;
	logic [NOISE_W-1:0] noise_e;
	logic [LEVEL_W-1:0] level_e;
	logic               sync_e;

	assign phase_e = adv_s1 ? phase_n : phase_acc_q;
	assign noise_e = adv_s1 ? noise_n : noise_q;
	assign level_e = adv_s1 ? level_n : env_level_q;
	assign sync_e  = adv_s1 && sync_n;

	// ---------------------------------------------------------------- waves
	logic               tri_fold;
	logic [WAVE_W-1:0]  tri_w;
	logic [WAVE_W-1:0]  saw_w;
	logic [WAVE_W-1:0]  sq_w;
	logic [WAVE_W-1:0]  noise_w;
	logic [WAVE_W-1:0]  wave_v;

	// and-combined waves, shifted up by one and clipped at full scale
	function automatic logic [WAVE_W-1:0] combine(input logic [WAVE_W-1:0] sq,
	                                              input logic [WAVE_W-1:0] w);
		logic [WAVE_W-1:0] m;
		m = sq & w & {1'b0, w[WAVE_W-1:1]} & {w[WAVE_W-2:0], 1'b0};
		return m[WAVE_W-1] ? {WAVE_W{1'b1}} : {m[WAVE_W-2:0], 1'b0};
	endfunction

	assign tri_fold = phase_e[23] ^ (ring_en & src_phase_s1[23]);
	assign tri_w    = tri_fold ? ~phase_e[22:7] : phase_e[22:7];
	assign saw_w    = phase_e[23:8];
	assign sq_w     = (phase_e[23:12] >= pw_q) ? {WAVE_W{1'b1}} : '0;
	assign noise_w  = {noise_e[20], noise_e[18], noise_e[14], noise_e[11],
	                   noise_e[9], noise_e[5], noise_e[2], noise_e[0], 8'h00};

	always_comb begin
		if (level_e == '0) begin
			wave_v = '0;
		end else begin
			case (wave_sel)
				WAVE_TRI:       wave_v = tri_w;
				WAVE_SAW:       wave_v = saw_w;
				WAVE_PULSE:     wave_v = sq_w;
				WAVE_PULSE_TRI: wave_v = combine(sq_w, tri_w);
				WAVE_PULSE_SAW: wave_v = combine(sq_w, saw_w);
				WAVE_PULSE_TS:  wave_v = combine(sq_w, tri_w & saw_w);
				WAVE_NOISE:     wave_v = noise_w;
				default:        wave_v = '0;
			endcase
		end
	end

	// offset-binary to signed is an msb flip; one 16x9 signed multiply
	logic signed [WAVE_W-1:0]  wave_s;
	logic signed [LEVEL_W:0]   level_s;
	logic signed [WAVE_W+LEVEL_W:0] product;

	assign wave_s  = {~wave_v[WAVE_W-1], wave_v[WAVE_W-2:0]};
	assign level_s = {1'b0, level_e};
	assign product = (WAVE_W+LEVEL_W+1)'(wave_s) * (WAVE_W+LEVEL_W+1)'(level_s);

	// --------------------------------------------------------------- registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q <= '0;
			pw_q   <= '0;
			ctrl_q <= '0;
			ad_q   <= '0;
			sr_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FREQUENCY:       freq_q <= cfg_data;
				REG_PULSE_WIDTH:     pw_q   <= cfg_data[PW_W-1:0];
				REG_CONTROL:         ctrl_q <= cfg_data[CTRL_W-1:0];
				REG_ATTACK_DECAY:    ad_q   <= cfg_data[7:0];
				REG_SUSTAIN_RELEASE: sr_q   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_acc_q <= '0;
			noise_q     <= NOISE_SEED;
			rate_cnt_q  <= '0;
			exp_cnt_q   <= '0;
			env_level_q <= '0;
			env_phase_q <= PH_RELEASE;
		end else if (stage_go && adv_s1) begin
			phase_acc_q <= phase_n;
			noise_q     <= noise_n;
			rate_cnt_q  <= rate_cnt_n;
			exp_cnt_q   <= exp_cnt_n;
			env_level_q <= level_n;
			env_phase_q <= ph_n;
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			adv_s1       <= s_tdata[0];
			src_phase_s1 <= s_tdata[24:1];
			src_sync_s1  <= s_tdata[25];
		end
	end

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (stage_go) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stage_go) begin
			out_data_q <= {7'b0, phase_e, sync_e, product[23:0], level_e, wave_v};
		end
	end

`ifndef ASSERT_OFF
	// an item without advance leaves the voice untouched and flags no sync
	a_no_advance_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(stage_go && !adv_s1) |=> ($stable(phase_acc_q) && $stable(env_level_q)
			&& $stable(noise_q) && !out_data_q[48]))
		else $error("voice state moved on a non-advancing beat");

	// test bit clears the accumulator on every advancing tick
	a_test_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(stage_go && adv_s1 && test_en) |=> (phase_acc_q == '0))
		else $error("accumulator not cleared under test bit");

	// the noise register can never fall into the all-zero lockup
	a_noise_alive: assert property (@(posedge clk) disable iff (!arst_n)
		noise_q != '0)
		else $error("noise shift register reached zero");

	// attack only ever raises the level
	a_attack_up: assert property (@(posedge clk) disable iff (!arst_n)
		(stage_go && adv_s1 && gate && env_phase_q != PH_DECAY)
			|=> (env_level_q >= $past(env_level_q)))
		else $error("envelope fell during attack");

	// a waiting input beat is never dropped
	a_s1_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !stage_go) |=> valid_s1)
		else $error("pending input beat lost");
`endif

endmodule

// ===== tb/tb_synth_voice_osc_adsr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_synth_voice_osc_adsr: self-checking bench for one oscillator voice
// a scoreboard class carries its own model of the envelope, accumulator,
// noise register and wave mixing; every accepted input beat queues the
// expected result, every output beat is checked field by field against it
// ----------------------------------------------------------------------------
module tb_synth_voice_osc_adsr;
	import svoa_pkg::*;

	// control register bit positions
	localparam int CTL_GATE = 0;
	localparam int CTL_SYNC = 1;
	localparam int CTL_RING = 2;
	localparam int CTL_TEST = 3;

	// waveform codes the voice leaves silent
	localparam logic [3:0] WAVE_NONE = 4'h0;
	localparam logic [3:0] WAVE_TOP  = 4'hf;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int LONG_HOLD      = 80;
	localparam int SETTLE_CYCLES  = 4;

	// one expected result beat
	typedef struct {
		logic [15:0] wave;
		logic [7:0]  level;
		logic [23:0] scaled;
		logic        sync;
		logic [23:0] phase;
	} voice_beat_t;

	// --------------------------------------------------------------------
	// scoreboard: voice model plus the queue of results still owed
	// --------------------------------------------------------------------
	class voice_scoreboard;
		logic [15:0] freq;
		logic [11:0] pw;
		logic [7:0]  ctrl;
		logic [7:0]  atk_dcy;
		logic [7:0]  sus_rel;
		logic [23:0] acc;
		logic [22:0] lfsr;
		logic [14:0] rate_cnt;
		logic [7:0]  exp_cnt;
		logic [7:0]  level;
		env_phase_t  stage;
		int          errors;
		voice_beat_t owed_q[$];
		int unsigned period_tab[16];

		function new();
			period_tab = '{9, 32, 63, 95, 149, 220, 267, 313,
				392, 977, 1954, 3126, 3907, 11720, 19532, 31251};
			freq     = '0;
			pw       = '0;
			ctrl     = '0;
			atk_dcy  = '0;
			sus_rel  = '0;
			acc      = '0;
			lfsr     = NOISE_SEED;
			rate_cnt = '0;
			exp_cnt  = '0;
			level    = '0;
			stage    = PH_RELEASE;
			errors   = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_FREQUENCY:       freq    = val;
				REG_PULSE_WIDTH:     pw      = val[11:0];
				REG_CONTROL:         ctrl    = val[7:0];
				REG_ATTACK_DECAY:    atk_dcy = val[7:0];
				REG_SUSTAIN_RELEASE: sus_rel = val[7:0];
				default: ;
			endcase
		endfunction

		// slower steps as the level nears zero
		function int exp_divider(logic [7:0] lvl);
			if (lvl == 0)
				return 1;
			else if (lvl < 6)
				return 30;
			else if (lvl < 14)
				return 16;
			else if (lvl < 26)
				return 8;
			else if (lvl < 52)
				return 4;
			else if (lvl < 93)
				return 2;
			return 1;
		endfunction

		function void envelope_tick();
			int unsigned period;
			if (ctrl[CTL_GATE]) begin
				if (stage != PH_ATTACK && stage != PH_DECAY)
					stage = PH_ATTACK;
			end else begin
				stage = PH_RELEASE;
			end
			case (stage)
				PH_ATTACK: period = period_tab[atk_dcy[7:4]];
				PH_DECAY:  period = period_tab[atk_dcy[3:0]];
				default:   period = period_tab[sus_rel[3:0]];
			endcase
			rate_cnt = rate_cnt + 15'd1;
			if (32'(rate_cnt) != period)
				return;
			rate_cnt = '0;
			if (stage == PH_ATTACK) begin
				exp_cnt = '0;
				if (level != LEVEL_MAX)
					level = level + 8'd1;
				if (level == LEVEL_MAX)
					stage = PH_DECAY;
			end else if (stage == PH_DECAY) begin
				exp_cnt = exp_cnt + 8'd1;
				if (int'(exp_cnt) >= exp_divider(level)) begin
					exp_cnt = '0;
					if (level > {sus_rel[7:4], sus_rel[7:4]})
						level = level - 8'd1;
				end
			end else if (level != 0) begin
				exp_cnt = exp_cnt + 8'd1;
				if (int'(exp_cnt) >= exp_divider(level)) begin
					exp_cnt = '0;
					level = level - 8'd1;
				end
			end
		endfunction

		function logic [15:0] triangle(logic [23:0] src);
			logic [23:0] t;
			logic        fold;
			fold = acc[23] ^ (ctrl[CTL_RING] & src[23]);
			t = fold ? ~acc : acc;
			return t[22:7];
		endfunction

		function logic [15:0] noise_bits();
			return {lfsr[20], lfsr[18], lfsr[14], lfsr[11],
				lfsr[9], lfsr[5], lfsr[2], lfsr[0], 8'h00};
		endfunction

		// combined waves: neighbor-bit and, shifted up, clipped at full scale
		function logic [15:0] pulse_and(logic [15:0] sq, logic [15:0] w);
			logic [16:0] c;
			c = {sq & w & (w >> 1) & (w << 1), 1'b0};
			return c[16] ? 16'hffff : c[15:0];
		endfunction

		function logic [15:0] wave_value(logic [23:0] src);
			logic [15:0] tri_v;
			logic [15:0] saw_v;
			logic [15:0] sq_v;
			tri_v = triangle(src);
			saw_v = acc[23:8];
			sq_v  = (acc[23:12] >= pw) ? 16'hffff : 16'h0000;
			if (level == 0)
				return 16'h0000;
			case (ctrl[7:4])
				WAVE_TRI:       return tri_v;
				WAVE_SAW:       return saw_v;
				WAVE_PULSE:     return sq_v;
				WAVE_PULSE_TRI: return pulse_and(sq_v, tri_v);
				WAVE_PULSE_SAW: return pulse_and(sq_v, saw_v);
				WAVE_PULSE_TS:  return pulse_and(sq_v, tri_v & saw_v);
				WAVE_NOISE:     return noise_bits();
				default:        return 16'h0000;
			endcase
		endfunction

		// one accepted input beat: run the tick and queue what comes out
		function void note_tick(logic adv, logic [23:0] src, logic sync_in);
			voice_beat_t r;
			logic [23:0] prev;
			int          prod;
			r.sync = 1'b0;
			if (adv) begin
				envelope_tick();
				if (ctrl[CTL_TEST]) begin
					acc = '0;
				end else if (freq != 0) begin
					prev = acc;
					acc = acc + {8'h00, freq};
					if (!prev[19] && acc[19])
						lfsr = {lfsr[21:0], lfsr[22] ^ lfsr[17]};
					if (!prev[23] && acc[23])
						r.sync = 1'b1;
				end
				if (ctrl[CTL_SYNC] && sync_in)
					acc = '0;
			end
			r.wave   = wave_value(src);
			r.level  = level;
			prod     = (int'(r.wave) - 32768) * int'(level);
			r.scaled = prod[23:0];
			r.phase  = acc;
			owed_q.push_back(r);
		endfunction

		function void report(string field, logic [23:0] want, logic [23:0] got);
			errors++;
			$error("%s mismatch: expected %0h, actual %0h", field, want, got);
		endfunction

		function void check_beat(logic [M_DATA_W-1:0] word);
			voice_beat_t want;
			if (owed_q.size() == 0) begin
				errors++;
				$error("result beat with no tick pending: %h", word);
				return;
			end
			want = owed_q.pop_front();
			if (word[15:0] !== want.wave)
				report("wave_value", 24'(want.wave), 24'(word[15:0]));
			if (word[23:16] !== want.level)
				report("envelope_level", 24'(want.level), 24'(word[23:16]));
			if (word[47:24] !== want.scaled)
				report("scaled_sample", want.scaled, word[47:24]);
			if (word[48] !== want.sync)
				report("sync_pulse", 24'(want.sync), 24'(word[48]));
			if (word[72:49] !== want.phase)
				report("phase", want.phase, word[72:49]);
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_DATA_W-1:0]   s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_DATA_W-1:0]   m_tdata;

	voice_scoreboard sb = new();

	// no idling on either side while set
	bit calm      = 1'b0;
	// asks the receiver for one long hold-off
	bit hold_req  = 1'b0;
	int quiet_cnt = 0;

	logic [3:0] wave_list [0:8];

	synth_voice_osc_adsr uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// receiver: ready with random stall bursts, plus one long hold on request
	initial begin
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	// monitor: sample between edges, act on the edge; also the watchdog
	always begin : monitor
		logic                in_fire;
		logic                out_fire;
		logic [M_DATA_W-1:0] out_word;
		@(negedge clk);
		in_fire  = (s_tvalid === 1'b1) && (s_tready === 1'b1);
		out_fire = (m_tvalid === 1'b1) && (m_tready === 1'b1);
		out_word = m_tdata;
		@(posedge clk);
		if (out_fire)
			sb.check_beat(out_word);
		if (in_fire || out_fire)
			quiet_cnt = 0;
		else
			quiet_cnt++;
		if (quiet_cnt >= WATCHDOG_LIMIT) begin
			$display("tb_synth_voice_osc_adsr failed");
			$finish;
		end
	end

	function automatic logic [7:0] ctrl_byte(logic [3:0] wave, logic test, logic ring,
		logic sync, logic gate);
		return {wave, test, ring, sync, gate};
	endfunction

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		sb.write_reg(idx, val);
	endtask

	// all five registers back to back, enable dropped once at the end
	task automatic load_voice_regs(input logic [15:0] f, input logic [11:0] p,
		input logic [7:0] c, input logic [7:0] ad, input logic [7:0] sr);
		put_reg(REG_FREQUENCY, f);
		put_reg(REG_PULSE_WIDTH, {4'h0, p});
		put_reg(REG_CONTROL, {8'h00, c});
		put_reg(REG_ATTACK_DECAY, {8'h00, ad});
		put_reg(REG_SUSTAIN_RELEASE, {8'h00, sr});
		cfg_we <= 1'b0;
	endtask

	// stop offering and let every owed result come out
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (sb.owed_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_tick(input logic adv, input logic [23:0] src, input logic sy);
		logic seen;
		if (!calm && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {6'b0, sy, src, adv};
		seen = 1'b0;
		while (!seen) begin
			@(negedge clk);
			seen = (s_tready === 1'b1);
			@(posedge clk);
		end
		sb.note_tick(adv, src, sy);
	endtask

	task automatic run_segment(input int count);
		logic        adv;
		logic [23:0] src;
		logic        sy;
		for (int i = 0; i < count; i++) begin
			adv = ($urandom_range(0, 9) != 0);
			case ($urandom_range(0, 7))
				0:       src = 24'h000000;
				1:       src = 24'hffffff;
				default: src = 24'($urandom);
			endcase
			sy = ($urandom_range(0, 3) == 0);
			send_tick(adv, src, sy);
		end
	endtask

	// random oscillator settings, envelope registers chosen by the caller
	task automatic random_regs(input logic gate, input logic [7:0] ad, input logic [7:0] sr);
		logic [15:0] f;
		logic [11:0] p;
		logic [3:0]  wv;
		logic        test;
		logic        ring;
		logic        sy;
		case ($urandom_range(0, 9))
			0:       f = 16'h0000;
			1:       f = 16'hffff;
			2:       f = 16'($urandom_range(1, 255));
			default: f = 16'($urandom);
		endcase
		case ($urandom_range(0, 5))
			0:       p = 12'h000;
			1:       p = 12'hfff;
			default: p = 12'($urandom);
		endcase
		if ($urandom_range(0, 9) < 7)
			wv = wave_list[$urandom_range(0, 6)];
		else
			wv = 4'($urandom);
		test = ($urandom_range(0, 11) == 0);
		ring = 1'($urandom_range(0, 1));
		sy   = 1'($urandom_range(0, 1));
		load_voice_regs(f, p, ctrl_byte(wv, test, ring, sy, gate), ad, sr);
	endtask

	initial begin : stimulus
		int         seg;
		logic [3:0] sus_nib;
		logic [7:0] sus_goal;

		wave_list = '{WAVE_TRI, WAVE_SAW, WAVE_PULSE, WAVE_PULSE_TRI, WAVE_PULSE_SAW,
			WAVE_PULSE_TS, WAVE_NOISE, WAVE_NONE, WAVE_TOP};
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= REG_FREQUENCY;
		cfg_data  <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed part ----
		// reset settings: a read-only beat, then a tick at zero frequency
		// with the envelope resting at zero in release
		send_tick(1'b0, 24'hffffff, 1'b1);
		send_tick(1'b1, 24'h000000, 1'b0);
		wait_drained();

		// fastest attack at full frequency lifts the level off zero
		load_voice_regs(16'hffff, 12'h000, ctrl_byte(WAVE_SAW, 1'b0, 1'b0, 1'b0, 1'b1),
			8'h00, 8'hf0);
		for (int i = 0; i < 10; i++)
			send_tick(1'b1, i[0] ? 24'hffffff : 24'h000000, i[0]);

		// every listed waveform select once, ring mod on, pulse width 0x800 or 0xfff
		for (int k = 0; k < 9; k++) begin
			wait_drained();
			load_voice_regs(16'hffff, k[0] ? 12'hfff : 12'h800,
				ctrl_byte(wave_list[k], 1'b0, 1'b1, 1'b0, 1'b1), 8'h00, 8'hf0);
			send_tick(1'b1, 24'($urandom), k[0]);
		end

		// test bit clears the accumulator
		wait_drained();
		load_voice_regs(16'hffff, 12'h800, ctrl_byte(WAVE_TRI, 1'b1, 1'b0, 1'b0, 1'b1),
			8'h00, 8'hf0);
		send_tick(1'b1, 24'hffffff, 1'b1);

		// hard sync from the neighbor pulse
		wait_drained();
		load_voice_regs(16'hffff, 12'h800, ctrl_byte(WAVE_SAW, 1'b0, 1'b0, 1'b1, 1'b1),
			8'h00, 8'hf0);
		send_tick(1'b1, 24'hffffff, 1'b1);

		// ---- release down to zero, then sit there a while ----
		seg = 0;
		while (sb.level != 0 && seg < 12) begin
			wait_drained();
			random_regs(1'b0, 8'($urandom), {4'($urandom_range(0, 15)), 4'h0});
			run_segment(60);
			seg++;
		end
		wait_drained();
		random_regs(1'b0, 8'($urandom), {4'($urandom_range(0, 15)), 4'h0});
		run_segment(60);

		// ---- fastest attack climbing from zero toward a high sustain ----
		// the first segment starts with the receiver held off so the block
		// fills up and back-pressures the sender
		sus_nib  = 4'($urandom_range(13, 15));
		sus_goal = {sus_nib, sus_nib};
		seg = 0;
		while (!(sb.stage == PH_DECAY && sb.level <= sus_goal) && seg < 2) begin
			wait_drained();
			random_regs(1'b1, 8'h00, {sus_nib, 4'($urandom_range(0, 15))});
			if (seg == 0)
				hold_req = 1'b1;
			run_segment(100);
			seg++;
		end

		// ---- anything goes: random gate and rates; last stretch without idling ----
		for (int k = 0; k < 5; k++) begin
			wait_drained();
			if (k >= 3)
				calm = 1'b1;
			random_regs(1'($urandom_range(0, 1)), 8'($urandom), 8'($urandom));
			run_segment(60);
		end

		wait_drained();
		if (sb.errors == 0)
			$display("tb_synth_voice_osc_adsr passed");
		else
			$display("tb_synth_voice_osc_adsr failed");
		$finish;
	end

endmodule
